/* src/telnet_iac_stream_parser_macros.svh */
// assertion macros for the telnet iac stream parser
// no dependencies; included by the modules that carry assertions
`ifndef TELNET_IAC_STREAM_PARSER_MACROS_SVH
`define TELNET_IAC_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property under clock and active-low reset
`define TISP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define TISP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TISP_ASSERT(lbl, clk, rst_n, prop, msg)

`define TISP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/tisp_pkg.sv */
// shared types and constants of the telnet iac stream parser
// no dependencies; used by tisp_parser and telnet_iac_stream_parser
package tisp_pkg;

    // telnet command codes
    localparam logic [7:0] TEL_IAC  = 8'hFF;
    localparam logic [7:0] TEL_DONT = 8'hFE;
    localparam logic [7:0] TEL_DO   = 8'hFD;
    localparam logic [7:0] TEL_WONT = 8'hFC;
    localparam logic [7:0] TEL_WILL = 8'hFB;
    localparam logic [7:0] TEL_SB   = 8'hFA;
    localparam logic [7:0] TEL_SE   = 8'hF0;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OPTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OPTION = 2'd1;

    // option reset values: echo and suppress go-ahead
    localparam logic [7:0] OPT_FIRST_RESET  = 8'd1;
    localparam logic [7:0] OPT_SECOND_RESET = 8'd3;

    // reply run positions
    localparam logic [1:0] POS_IAC    = 2'd0;
    localparam logic [1:0] POS_VERB   = 2'd1;
    localparam logic [1:0] POS_OPTION = 2'd2;

    typedef enum logic [1:0] {
        PH_NORMAL = 2'd0,
        PH_IAC    = 2'd1,
        PH_VERB   = 2'd2,
        PH_SUBNEG = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } t_verb;

    // one run of results caused by one input byte
    typedef struct packed {
        logic       is_reply;   // 0 one data byte, 1 three-byte reply
        logic [7:0] verb_byte;  // reply verb, reply runs only
        logic [7:0] data_byte;  // data byte or option code
    } t_run;

endpackage

/* src/tisp_parser.sv */
// telnet command state machine: turns each accepted byte into zero or one run
// depends on tisp_pkg
module tisp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_opt_first,
    input  logic [7:0]        i_opt_second,
    output logic              o_run_valid,
    output tisp_pkg::t_run    o_run
);

    tisp_pkg::t_phase r_phase, n_phase;
    tisp_pkg::t_verb  r_verb, n_verb;
    logic             r_esc, n_esc;

    logic       opt_ok;
    logic [7:0] verb_diff;
    logic [7:0] reply_verb;

    assign opt_ok    = (i_rx_byte == i_opt_first) || (i_rx_byte == i_opt_second);
    assign verb_diff = i_rx_byte - tisp_pkg::TEL_WILL;

    // reply verb for a pending command
    always_comb begin
        case (r_verb)
            tisp_pkg::VERB_WILL: reply_verb = opt_ok ? tisp_pkg::TEL_DO : tisp_pkg::TEL_DONT;
            tisp_pkg::VERB_WONT: reply_verb = tisp_pkg::TEL_DONT;
            tisp_pkg::VERB_DO:   reply_verb = opt_ok ? tisp_pkg::TEL_WILL : tisp_pkg::TEL_WONT;
            default:             reply_verb = tisp_pkg::TEL_WONT;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tisp_pkg::PH_NORMAL;
            r_verb  <= tisp_pkg::VERB_WILL;
            r_esc   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_verb  <= n_verb;
            r_esc   <= n_esc;
        end
    end

    // next state and run output
    always_comb begin
        n_phase     = r_phase;
        n_verb      = r_verb;
        n_esc       = r_esc;
        o_run_valid = 1'b0;
        o_run       = '0;
        if (i_accept) begin
            case (r_phase)
                tisp_pkg::PH_NORMAL: begin
                    if (i_rx_byte == tisp_pkg::TEL_IAC) begin
                        n_phase = tisp_pkg::PH_IAC;
                    end else begin
                        o_run_valid     = 1'b1;
                        o_run.data_byte = i_rx_byte;
                    end
                end
                tisp_pkg::PH_IAC: begin
                    if (i_rx_byte == tisp_pkg::TEL_IAC) begin
                        n_phase         = tisp_pkg::PH_NORMAL;
                        o_run_valid     = 1'b1;
                        o_run.data_byte = tisp_pkg::TEL_IAC;
                    end else if (i_rx_byte == tisp_pkg::TEL_SB) begin
                        n_esc   = 1'b0;
                        n_phase = tisp_pkg::PH_SUBNEG;
                    end else if (i_rx_byte inside {[tisp_pkg::TEL_WILL:tisp_pkg::TEL_DONT]})
                    begin
                        n_verb  = tisp_pkg::t_verb'(verb_diff[1:0]);
                        n_phase = tisp_pkg::PH_VERB;
                    end else begin
                        n_phase = tisp_pkg::PH_NORMAL;
                    end
                end
                tisp_pkg::PH_VERB: begin
                    n_phase         = tisp_pkg::PH_NORMAL;
                    o_run_valid     = 1'b1;
                    o_run.is_reply  = 1'b1;
                    o_run.verb_byte = reply_verb;
                    o_run.data_byte = i_rx_byte;
                end
                tisp_pkg::PH_SUBNEG: begin
                    if (r_esc) begin
                        if (i_rx_byte == tisp_pkg::TEL_SE) begin
                            n_phase = tisp_pkg::PH_NORMAL;
                        end
                        n_esc = 1'b0;
                    end else if (i_rx_byte == tisp_pkg::TEL_IAC) begin
                        n_esc = 1'b1;
                    end
                end
                default: begin
                    n_phase = tisp_pkg::PH_NORMAL;
                end
            endcase
        end
    end

endmodule

/* src/telnet_iac_stream_parser.sv */
// telnet iac stream parser: one byte accepted per cycle while the buffer has room;
// runs are registered in a two-entry buffer and serialized from there, a data run as
// one byte, a reply run as iac, verb and option bytes. without output stalls the
// sustained rate is one byte per cycle on data and replies get one result per cycle.
// synchronous active-low reset clears parser state and buffer, loads options 1 and 3.
// depends on tisp_pkg, tisp_parser and telnet_iac_stream_parser_macros.svh
`include "telnet_iac_stream_parser_macros.svh"

module telnet_iac_stream_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input byte channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_stream_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_run,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tisp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic [7:0]     r_opt_first, r_opt_second;
    logic           in_xfer, out_xfer;
    logic           run_valid;
    tisp_pkg::t_run run;

    tisp_pkg::t_run r_buf [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count, n_count;
    logic [1:0]     r_pos, n_pos;
    tisp_pkg::t_run head;
    logic           pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opt_first  <= tisp_pkg::OPT_FIRST_RESET;
            r_opt_second <= tisp_pkg::OPT_SECOND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tisp_pkg::CFG_FIRST_OPTION:  r_opt_first  <= i_cfg_data;
                tisp_pkg::CFG_SECOND_OPTION: r_opt_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input transfer and parser
    assign o_in_stall = (r_count == 2'd2);
    assign in_xfer    = i_in_valid && !o_in_stall;

    tisp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_xfer),
        .i_rx_byte    (i_rx_byte),
        .i_opt_first  (r_opt_first),
        .i_opt_second (r_opt_second),
        .o_run_valid  (run_valid),
        .o_run        (run)
    );

    // run buffer storage
    always_ff @(posedge i_clk) begin
        if (run_valid) begin
            r_buf[r_wr_ptr] <= run;
        end
    end

    // output serializer over the head run
    assign head          = r_buf[r_rd_ptr];
    assign o_out_valid   = (r_count != 2'd0);
    assign out_xfer      = o_out_valid && !i_out_stall;
    assign o_stream_kind = head.is_reply;
    assign o_last_of_run = !head.is_reply || (r_pos == tisp_pkg::POS_OPTION);
    assign pop           = out_xfer && o_last_of_run;

    always_comb begin
        case (r_pos)
            tisp_pkg::POS_IAC:  o_out_byte = head.is_reply ? tisp_pkg::TEL_IAC : head.data_byte;
            tisp_pkg::POS_VERB: o_out_byte = head.verb_byte;
            default:            o_out_byte = head.data_byte;
        endcase
    end

    // buffer occupancy and run position
    always_comb begin
        case ({run_valid, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
        if (pop) begin
            n_pos = tisp_pkg::POS_IAC;
        end else if (out_xfer) begin
            n_pos = r_pos + 2'd1;
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_pos    <= tisp_pkg::POS_IAC;
        end else begin
            r_count <= n_count;
            r_pos   <= n_pos;
            if (run_valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // checks on the run buffer and serializer
    `TISP_ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_count == 2'd3, "run buffer overfilled")
    `TISP_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, run_valid && (r_count == 2'd2), "run written while full")
    `TISP_ASSERT(a_pos_reply, i_clk, i_rst_n, (r_pos != tisp_pkg::POS_IAC) |-> (o_out_valid && head.is_reply), "mid-run position without reply run")
    `TISP_ASSERT_NEVER(a_pos_range, i_clk, i_rst_n, r_pos == 2'd3, "run position out of range")
    `TISP_ASSERT(a_ptr_count, i_clk, i_rst_n, ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr), "buffer pointers disagree with count")

endmodule
